// ===== sv/quadratic_probe_hash_set_assert.svh =====
// assertion macros for the quadratic probe hash set
`ifndef QUADRATIC_PROBE_HASH_SET_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_SET_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QPH_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define QPH_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define QPH_ASSERT_IMPL(label, clk, rst_n, prop)
`define QPH_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== sv/qph_pkg.sv =====
// package of types and constants for the quadratic probe hash set
package qph_pkg;
    localparam int MAX_SLOTS = 1024;
    localparam int KEY_BITS = 31;
    localparam int IDX_BITS = $clog2(MAX_SLOTS);
    localparam int CNT_BITS = IDX_BITS + 1;
    localparam int MARK_BITS = 2;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] MARK_FREE = 2'd0;
    localparam logic [1:0] MARK_LIVE = 2'd1;
    localparam logic [1:0] MARK_GONE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [30:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] slot_index;
        logic [10:0] occupancy;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture item and start modulo
        logic mod_step;   // one bit of key modulo
        logic probe_init; // reset probe counter to home
        logic rd;         // issue memory read of current probe slot
        logic advance;    // next probe
        logic note_tomb;  // remember first free/removed slot
        logic wr_ins;     // write key live at chosen slot
        logic wr_rem;     // mark hit slot removed
        logic set_result; // latch result
        logic [1:0] res_status;
        logic use_hit;    // result slot from current probe (else first tomb)
        logic push;       // move latched result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic last_probe;
        logic is_free;
        logic is_hit;
        logic not_live;
        logic have_tomb;
        logic clearing;
        logic [1:0] op;
    } stat_t;
endpackage

// ===== sv/qph_ram.sv =====
// generic single port ram with registered read
module qph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/qph_datapath.sv =====
// datapath: modulo unit, probe address, key and mark memories, result
module qph_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  qph_pkg::in_item_t  in_item,
    input  logic [10:0]        cfg_slots,
    input  qph_pkg::cmd_t      cmd,
    output qph_pkg::stat_t     stat,
    output qph_pkg::out_item_t result
);
    localparam int IB = qph_pkg::IDX_BITS;
    localparam int CB = qph_pkg::CNT_BITS;
    localparam int KB = qph_pkg::KEY_BITS;
    localparam int MB = qph_pkg::MARK_BITS;

    logic [1:0] op_reg;
    logic [KB-1:0] key_reg;
    logic [CB-1:0] n_reg;
    logic [CB:0] rem_reg, rem_next;
    logic [$clog2(KB+1)-1:0] bit_reg;
    logic [CB-1:0] p_reg;
    logic [CB:0] addr_reg, addr_next;
    logic [CB:0] incr_reg;
    logic [IB-1:0] tomb_reg;
    logic tomb_v_reg;
    logic [CB-1:0] live_reg;
    logic [IB-1:0] clr_idx_reg;
    logic clr_busy_reg;
    logic [KB-1:0] rd_key;
    logic [MB-1:0] rd_mark;
    logic mark_we;
    logic [MB-1:0] mark_wdata;
    logic [IB-1:0] addr;
    logic [IB-1:0] hold_idx_reg;
    logic [CB-1:0] n_clamp;
    qph_pkg::out_item_t res_reg;

    // clamp slot count into legal range
    always_comb
    begin
        if (cfg_slots < 11'd2)
            n_clamp = CB'(2);
        else if (CB'(cfg_slots) > CB'(qph_pkg::MAX_SLOTS) || cfg_slots > 11'(qph_pkg::MAX_SLOTS))
            n_clamp = CB'(qph_pkg::MAX_SLOTS);
        else
            n_clamp = CB'(cfg_slots);
    end

    // restoring modulo step, one key bit per cycle
    always_comb
    begin
        logic [CB:0] t;
        t = {rem_reg[CB-1:0], key_reg[KB-1-bit_reg]};
        rem_next = (t >= {1'b0, n_reg}) ? t - {1'b0, n_reg} : t;
    end

    // next probe: home + p^2 via increments 2p+1
    always_comb
    begin
        logic [CB+1:0] s;
        s = {1'b0, addr_reg} + {1'b0, incr_reg};
        if (s >= {2'b0, n_reg})
            s = s - {2'b0, n_reg};
        addr_next = s[CB:0];
    end

    // shared memory address: clearing pass, insert, remove, probe
    always_comb
    begin
        priority if (clr_busy_reg)
            addr = clr_idx_reg;
        else if (cmd.wr_ins)
            addr = tomb_reg;
        else if (cmd.wr_rem)
            addr = hold_idx_reg;
        else
            addr = addr_reg[IB-1:0];
    end

    // mark write: free while clearing, live on insert, removed on remove
    assign mark_we = clr_busy_reg || cmd.wr_ins || cmd.wr_rem;
    assign mark_wdata = clr_busy_reg ? qph_pkg::MARK_FREE
        : (cmd.wr_ins ? qph_pkg::MARK_LIVE : qph_pkg::MARK_GONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            tomb_v_reg <= 1'b0;
            clr_idx_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            // one mark entry cleared per cycle after reset
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == IB'(qph_pkg::MAX_SLOTS - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (cmd.wr_ins)
                live_reg <= live_reg + 1'b1;
            if (cmd.wr_rem)
            begin
                if (live_reg != '0)
                    live_reg <= live_reg - 1'b1;
            end
            if (cmd.probe_init)
                tomb_v_reg <= 1'b0;
            else if (cmd.note_tomb && !tomb_v_reg)
                tomb_v_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_item.op;
            key_reg <= in_item.key_value;
            n_reg <= n_clamp;
            rem_reg <= '0;
            bit_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            rem_reg <= rem_next;
            bit_reg <= bit_reg + 1'b1;
        end
        if (cmd.probe_init)
        begin
            p_reg <= '0;
            addr_reg <= rem_reg;
            incr_reg <= (CB+1)'(1);
        end
        else if (cmd.advance)
        begin
            p_reg <= p_reg + 1'b1;
            addr_reg <= addr_next;
            incr_reg <= (incr_reg + (CB+1)'(2) >= {1'b0, n_reg})
                ? incr_reg + (CB+1)'(2) - {1'b0, n_reg} : incr_reg + (CB+1)'(2);
        end
        if (cmd.rd)
            hold_idx_reg <= addr_reg[IB-1:0];
        if (cmd.note_tomb && !tomb_v_reg)
            tomb_reg <= hold_idx_reg;
        if (cmd.set_result)
        begin
            res_reg.status <= cmd.res_status;
            res_reg.slot_index <= (cmd.res_status != qph_pkg::ST_OK) ? '0
                : (cmd.use_hit ? 10'(hold_idx_reg) : 10'(tomb_reg));
            res_reg.occupancy <= 11'(live_reg);
        end
        // output register, loaded once the previous result is taken
        if (cmd.push)
            result <= res_reg;
    end

    // key store
    qph_ram #(.WIDTH(KB), .DEPTH(qph_pkg::MAX_SLOTS)) u_keys (
        .clk(clk), .we(cmd.wr_ins), .addr(addr), .wdata(key_reg), .rdata(rd_key)
    );

    // slot mark store
    qph_ram #(.WIDTH(MB), .DEPTH(qph_pkg::MAX_SLOTS)) u_marks (
        .clk(clk), .we(mark_we), .addr(addr), .wdata(mark_wdata), .rdata(rd_mark)
    );

    always_comb
    begin
        stat.mod_done = (bit_reg == ($clog2(KB+1))'(KB));
        stat.last_probe = (p_reg == n_reg - 1'b1);
        stat.is_free = (rd_mark == qph_pkg::MARK_FREE);
        stat.is_hit = (rd_mark == qph_pkg::MARK_LIVE) && (rd_key == key_reg);
        stat.not_live = (rd_mark != qph_pkg::MARK_LIVE);
        stat.have_tomb = tomb_v_reg;
        stat.clearing = clr_busy_reg;
        stat.op = op_reg;
    end
endmodule

// ===== sv/qph_ctrl.sv =====
// controller state machine for lookup, insert and remove
module qph_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  qph_pkg::stat_t stat,
    output qph_pkg::cmd_t  cmd
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MOD     = 3'd1;
    localparam logic [2:0] S_RD      = 3'd2;
    localparam logic [2:0] S_CHK     = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;
    localparam logic [2:0] S_REM     = 3'd5;
    localparam logic [2:0] S_INS     = 3'd6;
    localparam logic [2:0] S_INS_RES = 3'd7;

    logic [2:0] state_reg, state_next;
    logic valid_reg, valid_next;

    assign in_stall = (state_reg != S_IDLE) || stat.clearing;
    assign out_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg && out_stall;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next = S_RD;
                end
                else
                    cmd.mod_step = 1'b1;
            end
            S_RD:
            begin
                cmd.rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // one probe: decide hit, stop or continue
                state_next = S_DONE;
                cmd.set_result = 1'b1;
                cmd.use_hit = 1'b1;
                cmd.note_tomb = stat.not_live;
                if (stat.op != qph_pkg::OP_INSERT && stat.op != qph_pkg::OP_REMOVE
                    && stat.op != qph_pkg::OP_SEARCH)
                    cmd.res_status = qph_pkg::ST_MISS;
                else if (stat.is_hit)
                begin
                    if (stat.op == qph_pkg::OP_INSERT)
                        cmd.res_status = qph_pkg::ST_DUP;
                    else
                        cmd.res_status = qph_pkg::ST_OK;
                    cmd.wr_rem = (stat.op == qph_pkg::OP_REMOVE);
                    cmd.set_result = (stat.op != qph_pkg::OP_REMOVE);
                    if (stat.op == qph_pkg::OP_REMOVE)
                        state_next = S_REM;
                end
                else if (stat.is_free || stat.last_probe)
                begin
                    if (stat.op == qph_pkg::OP_INSERT)
                    begin
                        if (stat.have_tomb || stat.not_live)
                        begin
                            cmd.wr_ins = 1'b0;
                            cmd.set_result = 1'b0;
                            state_next = S_INS;
                        end
                        else
                            cmd.res_status = qph_pkg::ST_FULL;
                    end
                    else
                        cmd.res_status = qph_pkg::ST_MISS;
                end
                else
                begin
                    cmd.set_result = 1'b0;
                    cmd.advance = 1'b1;
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                // wait until the output register is free
                if (!valid_reg || !out_stall)
                begin
                    cmd.push = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REM:
            begin
                // remove: result after count update
                cmd.set_result = 1'b1;
                cmd.use_hit = 1'b1;
                cmd.res_status = qph_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_INS:
            begin
                // insert write at first non-live slot
                cmd.wr_ins = 1'b1;
                state_next = S_INS_RES;
            end
            S_INS_RES:
            begin
                cmd.set_result = 1'b1;
                cmd.res_status = qph_pkg::ST_OK;
                state_next = S_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end
endmodule

// ===== sv/quadratic_probe_hash_set.sv =====
// top level of the quadratic probe hash set
//  channel | signals                        | direction
//  in      | in_valid, in_stall, in_item    | transaction in
//  out     | out_valid, out_stall, out_item | transaction out
//  cfg     | cfg_we, cfg_data               | write only
// a transaction runs a bit-serial key modulo (31 bit steps and a setup step),
// a read and a check state per probe on the memory port, then S_REM for a remove
// or S_INS and S_INS_RES for an insert, then S_DONE; S_IDLE follows.
// reset clears the count and sets the slot count to 1021 at once; the mark memory
// is then cleared in a pass over its 1024 entries while the input is stalled.
// a waiting result sits in the output register; the next transaction runs and
// then waits in its last state until the output register is taken.
module quadratic_probe_hash_set (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  qph_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output qph_pkg::out_item_t out_item,
    input  logic               cfg_we,
    input  logic [10:0]        cfg_data
);
    `include "quadratic_probe_hash_set_assert.svh"

    logic [10:0] slots_reg;
    logic out_wait;
    qph_pkg::cmd_t cmd;
    qph_pkg::stat_t stat;

    // slot count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slots_reg <= 11'd1021;
        else if (cfg_we)
            slots_reg <= cfg_data;
    end

    qph_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    qph_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .cfg_slots(slots_reg),
        .cmd(cmd), .stat(stat), .result(out_item)
    );

    assign out_wait = out_valid && out_stall;

    `QPH_ASSERT_IMPL(a_out_hold, clk, rst_n, out_wait |=> out_valid && $stable(out_item))
    `QPH_ASSERT_NEVER(a_one_write, clk, rst_n, cmd.wr_ins && cmd.wr_rem)
    `QPH_ASSERT_IMPL(a_ok_count, clk, rst_n, out_valid |-> out_item.occupancy <= 11'(qph_pkg::MAX_SLOTS))
endmodule
